// ----- hdl/smss_pkg.sv -----
// Shared types, constants and the control store of the mean and deviation core.
package smss_pkg;

  // Fixed field widths.
  localparam int unsigned PRICE_W       = 16;
  localparam int unsigned FRAC_W        = 8;
  localparam int unsigned COUNT_W       = 9;
  localparam int unsigned MAX_ITEMS_DEF = 256;

  // Width of the step counter.
  localparam int unsigned PC_W = 5;

  // Step addresses of the control program.
  localparam logic [PC_W-1:0] ST_IDLE      = 5'd0;
  localparam logic [PC_W-1:0] ST_CHECK     = 5'd1;
  localparam logic [PC_W-1:0] ST_MEAN_INIT = 5'd2;
  localparam logic [PC_W-1:0] ST_MEAN_DIV  = 5'd3;
  localparam logic [PC_W-1:0] ST_MEAN_SAVE = 5'd4;
  localparam logic [PC_W-1:0] ST_RD_WAIT   = 5'd5;
  localparam logic [PC_W-1:0] ST_DIFF      = 5'd6;
  localparam logic [PC_W-1:0] ST_SQUARE    = 5'd7;
  localparam logic [PC_W-1:0] ST_ACC       = 5'd8;
  localparam logic [PC_W-1:0] ST_DEV_INIT  = 5'd9;
  localparam logic [PC_W-1:0] ST_DEV_DIV   = 5'd10;
  localparam logic [PC_W-1:0] ST_DEV_RINIT = 5'd11;
  localparam logic [PC_W-1:0] ST_DEV_ROOT  = 5'd12;
  localparam logic [PC_W-1:0] ST_DEV_SAVE  = 5'd13;
  localparam logic [PC_W-1:0] ST_NN_MUL    = 5'd14;
  localparam logic [PC_W-1:0] ST_SE_INIT   = 5'd15;
  localparam logic [PC_W-1:0] ST_SE_DIV    = 5'd16;
  localparam logic [PC_W-1:0] ST_SE_RINIT  = 5'd17;
  localparam logic [PC_W-1:0] ST_SE_ROOT   = 5'd18;
  localparam logic [PC_W-1:0] ST_SE_SAVE   = 5'd19;
  localparam logic [PC_W-1:0] ST_WAIT_OUT  = 5'd20;
  localparam logic [PC_W-1:0] ST_EMIT      = 5'd21;
  localparam logic [PC_W-1:0] ST_WAIT_ERR  = 5'd22;
  localparam logic [PC_W-1:0] ST_EMIT_ERR  = 5'd23;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_MEAN_INIT,
    OP_DIV_STEP,
    OP_MEAN_SAVE,
    OP_DIFF,
    OP_SQUARE,
    OP_ACC,
    OP_DEV_INIT,
    OP_ROOT_INIT,
    OP_ROOT_STEP,
    OP_DEV_SAVE,
    OP_NN_MUL,
    OP_SE_INIT,
    OP_SE_SAVE,
    OP_EMIT,
    OP_EMIT_ERR
  } op_e;

  // Jump conditions: the jump is taken when the condition holds.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_SHORT,
    C_ITER,
    C_IDX,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  // Status from the datapath that the jumps test.
  typedef struct packed {
    logic start;
    logic short_list;
    logic iter_more;
    logic idx_more;
    logic out_busy;
  } flags_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    op_e  op;
    logic idle;
  } ctrl_t;

  // The control program.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      ST_IDLE:      w = '{op: OP_NOP,       cond: C_NO_START, target: ST_IDLE};
      ST_CHECK:     w = '{op: OP_NOP,       cond: C_SHORT,    target: ST_WAIT_ERR};
      ST_MEAN_INIT: w = '{op: OP_MEAN_INIT, cond: C_NEVER,    target: ST_IDLE};
      ST_MEAN_DIV:  w = '{op: OP_DIV_STEP,  cond: C_ITER,     target: ST_MEAN_DIV};
      ST_MEAN_SAVE: w = '{op: OP_MEAN_SAVE, cond: C_NEVER,    target: ST_IDLE};
      ST_RD_WAIT:   w = '{op: OP_NOP,       cond: C_NEVER,    target: ST_IDLE};
      ST_DIFF:      w = '{op: OP_DIFF,      cond: C_NEVER,    target: ST_IDLE};
      ST_SQUARE:    w = '{op: OP_SQUARE,    cond: C_NEVER,    target: ST_IDLE};
      ST_ACC:       w = '{op: OP_ACC,       cond: C_IDX,      target: ST_RD_WAIT};
      ST_DEV_INIT:  w = '{op: OP_DEV_INIT,  cond: C_NEVER,    target: ST_IDLE};
      ST_DEV_DIV:   w = '{op: OP_DIV_STEP,  cond: C_ITER,     target: ST_DEV_DIV};
      ST_DEV_RINIT: w = '{op: OP_ROOT_INIT, cond: C_NEVER,    target: ST_IDLE};
      ST_DEV_ROOT:  w = '{op: OP_ROOT_STEP, cond: C_ITER,     target: ST_DEV_ROOT};
      ST_DEV_SAVE:  w = '{op: OP_DEV_SAVE,  cond: C_NEVER,    target: ST_IDLE};
      ST_NN_MUL:    w = '{op: OP_NN_MUL,    cond: C_NEVER,    target: ST_IDLE};
      ST_SE_INIT:   w = '{op: OP_SE_INIT,   cond: C_NEVER,    target: ST_IDLE};
      ST_SE_DIV:    w = '{op: OP_DIV_STEP,  cond: C_ITER,     target: ST_SE_DIV};
      ST_SE_RINIT:  w = '{op: OP_ROOT_INIT, cond: C_NEVER,    target: ST_IDLE};
      ST_SE_ROOT:   w = '{op: OP_ROOT_STEP, cond: C_ITER,     target: ST_SE_ROOT};
      ST_SE_SAVE:   w = '{op: OP_SE_SAVE,   cond: C_NEVER,    target: ST_IDLE};
      ST_WAIT_OUT:  w = '{op: OP_NOP,       cond: C_OUT_BUSY, target: ST_WAIT_OUT};
      ST_EMIT:      w = '{op: OP_EMIT,      cond: C_ALWAYS,   target: ST_IDLE};
      ST_WAIT_ERR:  w = '{op: OP_NOP,       cond: C_OUT_BUSY, target: ST_WAIT_ERR};
      ST_EMIT_ERR:  w = '{op: OP_EMIT_ERR,  cond: C_ALWAYS,   target: ST_IDLE};
      default:      w = '{op: OP_NOP,       cond: C_ALWAYS,   target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/smss_store.sv -----
// Price store: one write port for loading, one registered read port for the second pass.
module smss_store #(
  parameter int unsigned DEPTH = smss_pkg::MAX_ITEMS_DEF
) (
  input  logic                             clk_i,
  input  logic                             wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr_i,
  input  logic [smss_pkg::PRICE_W-1:0]     wr_data_i,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr_i,
  output logic [smss_pkg::PRICE_W-1:0]     rd_data_o
);

  logic [smss_pkg::PRICE_W-1:0] mem [DEPTH];
  logic [smss_pkg::PRICE_W-1:0] rd_data_q;

  // Write while loading a list.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read every cycle; the data is registered and valid in the cycle after the address.
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hdl/smss_div.sv -----
// Restoring divider: one quotient bit per step, most significant first.
module smss_div #(
  parameter int unsigned DVD_W = 59,
  parameter int unsigned DSR_W = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic             step_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  output logic [DVD_W-1:0] quotient_o,
  output logic             more_o
);

  localparam int unsigned CW = $clog2(DVD_W + 1);

  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DSR_W-1:0] dsr_q, dsr_d;
  logic [DSR_W-1:0] rem_q, rem_d;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   trial_sub;
  logic             ge;

  // Bring down the next dividend bit and try a subtraction.
  assign trial     = {rem_q, dvd_q[DVD_W-1]};
  assign trial_sub = trial - {1'b0, dsr_q};
  assign ge        = trial >= {1'b0, dsr_q};

  always_comb begin
    cnt_d = cnt_q;
    dvd_d = dvd_q;
    dsr_d = dsr_q;
    rem_d = rem_q;
    if (load_i) begin
      cnt_d = CW'(DVD_W);
      dvd_d = dividend_i;
      dsr_d = divisor_i;
      rem_d = '0;
    end else if (step_i) begin
      cnt_d = cnt_q - CW'(1);
      dvd_d = {dvd_q[DVD_W-2:0], ge};
      rem_d = ge ? trial_sub[DSR_W-1:0] : trial[DSR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  // Once all bits are through, the shifted dividend holds the quotient.
  assign quotient_o = dvd_q;
  assign more_o     = cnt_q > CW'(1);

endmodule

// ----- hdl/smss_root.sv -----
// Integer square root, two radicand bits per step.
module smss_root #(
  parameter int unsigned SQ_W = 60
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  logic            step_i,
  input  logic [SQ_W-1:0] radicand_i,
  output logic [SQ_W-1:0] root_o,
  output logic            more_o
);

  localparam int unsigned STEPS = SQ_W / 2;
  localparam int unsigned CW    = $clog2(STEPS + 1);

  logic [CW-1:0]   cnt_q, cnt_d;
  logic [SQ_W-1:0] v_q, v_d;
  logic [SQ_W-1:0] res_q, res_d;
  logic [SQ_W-1:0] bit_q, bit_d;
  logic [SQ_W:0]   trial;
  logic            ge;

  // Compare the remainder against the current root plus the trial bit.
  assign trial = {1'b0, res_q} + {1'b0, bit_q};
  assign ge    = {1'b0, v_q} >= trial;

  always_comb begin
    cnt_d = cnt_q;
    v_d   = v_q;
    res_d = res_q;
    bit_d = bit_q;
    if (load_i) begin
      cnt_d = CW'(STEPS);
      v_d   = radicand_i;
      res_d = '0;
      bit_d = {2'b01, {(SQ_W-2){1'b0}}};
    end else if (step_i) begin
      cnt_d = cnt_q - CW'(1);
      bit_d = bit_q >> 2;
      if (ge) begin
        v_d   = v_q - trial[SQ_W-1:0];
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign root_o = res_q;
  assign more_o = cnt_q > CW'(1);

endmodule

// ----- hdl/smss_seq.sv -----
// Step counter and control store: each step issues one operation and may jump.
module smss_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  smss_pkg::flags_t flags_i,
  output smss_pkg::ctrl_t  ctrl_o
);

  logic [smss_pkg::PC_W-1:0] pc_q, pc_d;
  smss_pkg::uword_t          uw;
  logic                      take;

  assign uw = smss_pkg::ucode(pc_q);

  // Evaluate the jump condition of the current control word.
  always_comb begin
    unique case (uw.cond)
      smss_pkg::C_NEVER:    take = 1'b0;
      smss_pkg::C_ALWAYS:   take = 1'b1;
      smss_pkg::C_NO_START: take = !flags_i.start;
      smss_pkg::C_SHORT:    take = flags_i.short_list;
      smss_pkg::C_ITER:     take = flags_i.iter_more;
      smss_pkg::C_IDX:      take = flags_i.idx_more;
      smss_pkg::C_OUT_BUSY: take = flags_i.out_busy;
      default:              take = 1'b0;
    endcase
    pc_d = take ? uw.target : pc_q + smss_pkg::PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= smss_pkg::ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.op   = uw.op;
  assign ctrl_o.idle = pc_q == smss_pkg::ST_IDLE;

endmodule

// ----- hdl/sample_mean_stddev_stderr_core.sv -----
// Channel | Direction | Handshake               | Word
// in      | input     | in_valid_i / in_ready_o | price_cents_i, present_i, last_i
// out     | output    | out_valid_o/out_ready_i | mean, deviation, error, count, error flag
//
// Loading takes one word per cycle while the sequencer sits in its idle step.
// With n prices and the default depth, the work after the last word is three 59-step
// divisions, two 30-step roots and four steps per price.
// Fewer than two prices skip this work and give an error result once the output is free.
// Reset clears the counters and the sequencer; the store needs no clearing pass.
// A waiting result does not stop loading; the next list waits for it only at the end.
module sample_mean_stddev_stderr_core #(
  parameter int unsigned MAX_ITEMS = smss_pkg::MAX_ITEMS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [smss_pkg::PRICE_W-1:0]     price_cents_i,
  input  logic                             present_i,
  input  logic                             last_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [smss_pkg::PRICE_W-1:0]     mean_cents_o,
  output logic [smss_pkg::PRICE_W-1:0]     std_dev_cents_o,
  output logic [smss_pkg::PRICE_W-1:0]     std_error_cents_o,
  output logic [smss_pkg::COUNT_W-1:0]     count_o,
  output logic                             error_o
);

  localparam int unsigned PW      = smss_pkg::PRICE_W;
  localparam int unsigned FW      = smss_pkg::FRAC_W;
  localparam int unsigned CNT_W   = $clog2(MAX_ITEMS + 1);
  localparam int unsigned ADDR_W  = $clog2(MAX_ITEMS);
  localparam int unsigned SUM_W   = PW + CNT_W;
  localparam int unsigned MEAN_W  = PW + FW;
  localparam int unsigned MD_W    = SUM_W + FW;
  localparam int unsigned SQP_W   = 2 * MEAN_W;
  localparam int unsigned SSD_W   = SQP_W + CNT_W;
  localparam int unsigned DVD_W   = SSD_W + 2;
  localparam int unsigned DSR_W   = 2 * CNT_W;
  localparam int unsigned SQ_W    = DVD_W + (DVD_W % 2);
  localparam int unsigned RSH     = FW + 1;

  smss_pkg::ctrl_t  ctrl;
  smss_pkg::flags_t flags;

  // List state.
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d;

  // Working registers of the program.
  logic [MEAN_W-1:0] mean_q, mean_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [MEAN_W-1:0] diff_q, diff_d;
  logic [SQP_W-1:0]  sq_q, sq_d;
  logic [SSD_W-1:0]  ssd_q, ssd_d;
  logic [DSR_W-1:0]  prod_q, prod_d;
  logic [PW-1:0]     dev_q, dev_d;
  logic [PW-1:0]     se_q, se_d;

  // Result register.
  logic [PW-1:0]                  o_mean_q, o_mean_d;
  logic [PW-1:0]                  o_dev_q, o_dev_d;
  logic [PW-1:0]                  o_se_q, o_se_d;
  logic [smss_pkg::COUNT_W-1:0]   o_count_q, o_count_d;
  logic                           o_err_q, o_err_d;

  logic              in_acc;
  logic              store_wr;
  logic [PW-1:0]     rd_data;
  logic              full;
  logic              short_list;

  logic              div_load, div_step, div_more;
  logic [DVD_W-1:0]  div_dvd;
  logic [DSR_W-1:0]  div_dsr;
  logic [DVD_W-1:0]  quotient;
  logic              root_load, root_step, root_more;
  logic [SQ_W-1:0]   root;

  logic [MD_W-1:0]   mean_dvd;
  logic [DSR_W-1:0]  n_ext, nm1_ext;
  logic [MEAN_W-1:0] p8;
  logic [MEAN_W:0]   mean_rnd;
  logic [PW-1:0]     mean_cents;
  logic [SQ_W:0]     root_rnd;
  logic [PW-1:0]     root_cents;

  // Loading side.
  assign in_ready_o = ctrl.idle;
  assign in_acc     = in_valid_i && in_ready_o;
  assign full       = count_q == CNT_W'(MAX_ITEMS);
  assign store_wr   = in_acc && present_i && !full;
  assign short_list = count_q < CNT_W'(2);

  smss_store #(
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (store_wr),
    .wr_addr_i (count_q[ADDR_W-1:0]),
    .wr_data_i (price_cents_i),
    .rd_addr_i (idx_q[ADDR_W-1:0]),
    .rd_data_o (rd_data)
  );

  smss_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  assign flags.start      = in_acc && last_i;
  assign flags.short_list = short_list;
  assign flags.iter_more  = div_more || root_more;
  assign flags.idx_more   = (idx_q + CNT_W'(1)) != count_q;
  assign flags.out_busy   = out_valid_q && !out_ready_i;

  // Divider operands: rounded Q8 mean first, then the squared deviations twice.
  assign n_ext    = DSR_W'(count_q);
  assign nm1_ext  = n_ext - DSR_W'(1);
  assign mean_dvd = {sum_q, {FW{1'b0}}} + MD_W'(count_q >> 1);

  always_comb begin
    div_dvd = {ssd_q, 2'b00};
    div_dsr = nm1_ext;
    unique case (ctrl.op)
      smss_pkg::OP_MEAN_INIT: begin
        div_dvd = DVD_W'(mean_dvd);
        div_dsr = n_ext;
      end
      smss_pkg::OP_SE_INIT:   div_dsr = prod_q;
      default:                div_dsr = nm1_ext;
    endcase
  end

  assign div_load  = ctrl.op == smss_pkg::OP_MEAN_INIT || ctrl.op == smss_pkg::OP_DEV_INIT ||
                     ctrl.op == smss_pkg::OP_SE_INIT;
  assign div_step  = ctrl.op == smss_pkg::OP_DIV_STEP;
  assign root_load = ctrl.op == smss_pkg::OP_ROOT_INIT;
  assign root_step = ctrl.op == smss_pkg::OP_ROOT_STEP;

  smss_div #(
    .DVD_W (DVD_W),
    .DSR_W (DSR_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (div_load),
    .step_i     (div_step),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .quotient_o (quotient),
    .more_o     (div_more)
  );

  smss_root #(
    .SQ_W (SQ_W)
  ) u_root (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (root_load),
    .step_i     (root_step),
    .radicand_i (SQ_W'(quotient)),
    .root_o     (root),
    .more_o     (root_more)
  );

  // Round half up to cents and saturate.
  assign mean_rnd   = {1'b0, mean_q} + (MEAN_W+1)'(1 << (FW - 1));
  assign mean_cents = mean_rnd[MEAN_W] ? {PW{1'b1}} : mean_rnd[MEAN_W-1:FW];
  assign root_rnd   = {1'b0, root} + (SQ_W+1)'(1 << (RSH - 1));
  assign root_cents = (|root_rnd[SQ_W:RSH+PW]) ? {PW{1'b1}} : root_rnd[RSH+PW-1:RSH];
  assign p8         = {rd_data, {FW{1'b0}}};

  // Datapath: one operation per step, plus loading while idle.
  always_comb begin
    count_d     = count_q;
    sum_d       = sum_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mean_d      = mean_q;
    idx_d       = idx_q;
    diff_d      = diff_q;
    sq_d        = sq_q;
    ssd_d       = ssd_q;
    prod_d      = prod_q;
    dev_d       = dev_q;
    se_d        = se_q;
    o_mean_d    = o_mean_q;
    o_dev_d     = o_dev_q;
    o_se_d      = o_se_q;
    o_count_d   = o_count_q;
    o_err_d     = o_err_q;

    if (in_acc && present_i) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CNT_W'(1);
        sum_d   = sum_q + SUM_W'(price_cents_i);
      end
    end

    unique case (ctrl.op)
      smss_pkg::OP_MEAN_SAVE: begin
        mean_d = quotient[MEAN_W-1:0];
        ssd_d  = '0;
        idx_d  = '0;
      end
      smss_pkg::OP_DIFF:   diff_d = (p8 >= mean_q) ? p8 - mean_q : mean_q - p8;
      smss_pkg::OP_SQUARE: sq_d = diff_q * diff_q;
      smss_pkg::OP_ACC: begin
        ssd_d = ssd_q + SSD_W'(sq_q);
        idx_d = idx_q + CNT_W'(1);
      end
      smss_pkg::OP_DEV_SAVE: dev_d = root_cents;
      smss_pkg::OP_NN_MUL:   prod_d = nm1_ext * n_ext;
      smss_pkg::OP_SE_SAVE:  se_d = root_cents;
      smss_pkg::OP_EMIT: begin
        out_valid_d = 1'b1;
        o_mean_d    = mean_cents;
        o_dev_d     = dev_q;
        o_se_d      = se_q;
        o_count_d   = smss_pkg::COUNT_W'(count_q);
        o_err_d     = ovf_q;
        count_d     = '0;
        sum_d       = '0;
        ovf_d       = 1'b0;
      end
      smss_pkg::OP_EMIT_ERR: begin
        out_valid_d = 1'b1;
        o_mean_d    = '0;
        o_dev_d     = '0;
        o_se_d      = '0;
        o_count_d   = smss_pkg::COUNT_W'(count_q);
        o_err_d     = 1'b1;
        count_d     = '0;
        sum_d       = '0;
        ovf_d       = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      sum_q       <= sum_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mean_q    <= mean_d;
    idx_q     <= idx_d;
    diff_q    <= diff_d;
    sq_q      <= sq_d;
    ssd_q     <= ssd_d;
    prod_q    <= prod_d;
    dev_q     <= dev_d;
    se_q      <= se_d;
    o_mean_q  <= o_mean_d;
    o_dev_q   <= o_dev_d;
    o_se_q    <= o_se_d;
    o_count_q <= o_count_d;
    o_err_q   <= o_err_d;
  end

  assign out_valid_o       = out_valid_q;
  assign mean_cents_o      = o_mean_q;
  assign std_dev_cents_o   = o_dev_q;
  assign std_error_cents_o = o_se_q;
  assign count_o           = o_count_q;
  assign error_o           = o_err_q;

  // The fill count never passes the store depth.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ITEMS))
    else $error("price count beyond store depth");

  // Giving a result leaves an empty list behind.
  a_list_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == smss_pkg::OP_EMIT || ctrl.op == smss_pkg::OP_EMIT_ERR)
    |=> (count_q == '0 && sum_q == '0 && !ovf_q))
    else $error("list state not cleared after result");

  // The divider and the root unit are never busy at once.
  a_units_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_more && root_more))
    else $error("divider and root unit overlap");

  // A unit is never restarted in the middle of its iterations.
  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_load || root_load) |-> !(div_more || root_more))
    else $error("unit restarted while busy");

endmodule
